### rtl/cnit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cnit_pkg;

  // Default depth of the queue between the classifier and the executor.
  localparam int QUEUE_DEPTH = 2;

  // Request codes as they arrive on the input channel.
  typedef enum logic [2:0] {
    REQ_TICK        = 3'd0,
    REQ_EN_WRITE    = 3'd1,
    REQ_TIMER_WRITE = 3'd2,
    REQ_NMI_READ    = 3'd3,
    REQ_IRQ_READ    = 3'd4,
    REQ_NMI_TEST    = 3'd5,
    REQ_IRQ_TEST    = 3'd6,
    REQ_NOP         = 3'd7
  } req_t;

  // Configuration register index.
  localparam logic REG_REGION_PAL = 1'b0;

  // Line where vertical blank begins, normal and overscan.
  localparam logic [8:0] VBLANK_LINE      = 9'd225;
  localparam logic [8:0] VBLANK_LINE_OVER = 9'd240;

  // One request after classification.
  typedef struct packed {
    req_t        op;
    logic        nmi_level;
    logic [8:0]  irq_vpos;
    logic [10:0] irq_hpos;
    logic        interlace;
    logic        field_odd;
    logic        en_nmi;
    logic        en_virq;
    logic        en_hirq;
    logic [8:0]  new_vtime;
    logic [8:0]  new_htime;
    logic        irq_disable;
  } item_t;

  // Queue fill status.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

### rtl/cnit_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cnit_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [8:0]  nmi_vpos;
  logic [8:0]  irq_vpos;
  logic [10:0] irq_hpos;
  logic        overscan;
  logic        interlace;
  logic        field_odd;
  logic [7:0]  write_data;
  logic [8:0]  new_vtime;
  logic [8:0]  new_htime;
  logic        irq_disable;

  modport source (
    output valid, req_type, nmi_vpos, irq_vpos, irq_hpos, overscan, interlace,
           field_odd, write_data, new_vtime, new_htime, irq_disable,
    input  ready
  );
  modport sink (
    input  valid, req_type, nmi_vpos, irq_vpos, irq_hpos, overscan, interlace,
           field_odd, write_data, new_vtime, new_htime, irq_disable,
    output ready
  );
endinterface

interface cnit_out_if;
  logic valid;
  logic ready;
  logic read_bit;
  logic nmi_taken;
  logic irq_taken;
  logic wake;
  logic nmi_line_out;
  logic irq_line_out;

  modport source (
    output valid, read_bit, nmi_taken, irq_taken, wake, nmi_line_out, irq_line_out,
    input  ready
  );
  modport sink (
    input  valid, read_bit, nmi_taken, irq_taken, wake, nmi_line_out, irq_line_out,
    output ready
  );
endinterface

`default_nettype wire

### rtl/cnit_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cnit_front (
  cnit_in_if.sink          in_ch,
  input  cnit_pkg::q_stat_t q_stat,
  output logic             push,
  output cnit_pkg::item_t  push_item
);

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  // Decode the request and reduce the NMI beam position to its vblank level.
  always_comb begin
    push_item.op          = cnit_pkg::req_t'(in_ch.req_type);
    push_item.nmi_level   = in_ch.nmi_vpos >= (in_ch.overscan ? cnit_pkg::VBLANK_LINE_OVER
                                                              : cnit_pkg::VBLANK_LINE);
    push_item.irq_vpos    = in_ch.irq_vpos;
    push_item.irq_hpos    = in_ch.irq_hpos;
    push_item.interlace   = in_ch.interlace;
    push_item.field_odd   = in_ch.field_odd;
    push_item.en_nmi      = in_ch.write_data[7];
    push_item.en_virq     = in_ch.write_data[5];
    push_item.en_hirq     = in_ch.write_data[4];
    push_item.new_vtime   = in_ch.new_vtime;
    push_item.new_htime   = in_ch.new_htime;
    push_item.irq_disable = in_ch.irq_disable;
  end

endmodule

`default_nettype wire

### rtl/cnit_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cnit_queue #(
  parameter int DEPTH = cnit_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cnit_pkg::item_t   push_item,
  input  logic              pop,
  output cnit_pkg::item_t   head,
  output cnit_pkg::q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cnit_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head         = mem[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == FULL_CNT);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

### rtl/cnit_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cnit_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              region_pal,
  input  cnit_pkg::item_t   head,
  input  cnit_pkg::q_stat_t q_stat,
  output logic              pop,
  cnit_out_if.source        out_ch
);

  localparam logic [8:0] LAST_DOT   = 9'd339;
  localparam logic [8:0] LIM_NTSC   = 9'd262;
  localparam logic [8:0] LIM_PAL    = 9'd312;
  localparam logic [8:0] ODD_LINE   = 9'd240;
  localparam logic [2:0] HOLD_START = 3'd4;

  function automatic logic [2:0] hold_dec(input logic [2:0] c);
    return (c >= 3'd2) ? c - 3'd2 : 3'd0;
  endfunction

  // False where the timer position can never produce a compare match.
  function automatic logic can_latch(input logic [8:0] v, input logic [8:0] h_raw,
                                     input logic hen, input logic pal,
                                     input logic il, input logic fo);
    logic [8:0] h;
    logic [8:0] lim;
    logic       ok;
    h   = hen ? h_raw : 9'd0;
    lim = pal ? LIM_PAL : LIM_NTSC;
    ok  = 1'b1;
    if (v == ODD_LINE && h == LAST_DOT && !il && fo) ok = 1'b0;
    if (v == lim - 9'd1 && h == LAST_DOT && !il) ok = 1'b0;
    if (v == lim && !il) ok = 1'b0;
    if (v == lim && h == LAST_DOT) ok = 1'b0;
    if (v > lim) ok = 1'b0;
    if (h > LAST_DOT) ok = 1'b0;
    return ok;
  endfunction

  logic        nmi_en_r, nmi_en_nxt;
  logic        virq_en_r, virq_en_nxt;
  logic        hirq_en_r, hirq_en_nxt;
  logic        nmi_pending_r, nmi_pending_nxt;
  logic        irq_pending_r, irq_pending_nxt;
  logic        nmi_flag_r, nmi_flag_nxt;
  logic        irq_flag_r, irq_flag_nxt;
  logic        nmi_level_prev_r, nmi_level_prev_nxt;
  logic        irq_match_prev_r, irq_match_prev_nxt;
  logic [2:0]  nmi_hold_r, nmi_hold_nxt;
  logic [2:0]  irq_hold_r, irq_hold_nxt;
  logic [8:0]  vtime_r, vtime_nxt;
  logic [8:0]  htime_r, htime_nxt;
  logic [8:0]  vtrigger_r, vtrigger_nxt;
  logic [10:0] htrigger_r, htrigger_nxt;
  logic        never_r, never_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        read_bit_r, read_bit_nxt;
  logic        nmi_taken_r, nmi_taken_nxt;
  logic        irq_taken_r, irq_taken_nxt;
  logic        wake_r, wake_nxt;
  logic        nmi_flag_out_r, irq_flag_out_r;

  logic        refresh;
  logic [8:0]  ref_v;
  logic [8:0]  ref_h;
  logic        ref_hen;
  logic [9:0]  h_sum;
  logic        match;

  assign pop = !q_stat.empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    nmi_en_nxt         = nmi_en_r;
    virq_en_nxt        = virq_en_r;
    hirq_en_nxt        = hirq_en_r;
    nmi_pending_nxt    = nmi_pending_r;
    irq_pending_nxt    = irq_pending_r;
    nmi_flag_nxt       = nmi_flag_r;
    irq_flag_nxt       = irq_flag_r;
    nmi_level_prev_nxt = nmi_level_prev_r;
    irq_match_prev_nxt = irq_match_prev_r;
    nmi_hold_nxt       = nmi_hold_r;
    irq_hold_nxt       = irq_hold_r;
    vtime_nxt          = vtime_r;
    htime_nxt          = htime_r;
    vtrigger_nxt       = vtrigger_r;
    htrigger_nxt       = htrigger_r;
    never_nxt          = never_r;
    read_bit_nxt       = 1'b0;
    nmi_taken_nxt      = 1'b0;
    irq_taken_nxt      = 1'b0;
    wake_nxt           = 1'b0;
    refresh            = 1'b0;
    ref_v              = vtime_r;
    ref_h              = htime_r;
    ref_hen            = hirq_en_r;
    match              = 1'b0;

    if (pop) begin
      case (head.op)
        cnit_pkg::REQ_TICK: begin
          if (nmi_hold_r != 3'd0) begin
            nmi_hold_nxt = hold_dec(nmi_hold_r);
            if (nmi_hold_nxt == 3'd0 && nmi_en_r) nmi_pending_nxt = 1'b1;
          end
          if (!nmi_level_prev_r && head.nmi_level) begin
            nmi_flag_nxt = 1'b1;
            nmi_hold_nxt = HOLD_START;
          end else if (nmi_level_prev_r && !head.nmi_level) begin
            nmi_flag_nxt = 1'b0;
          end
          nmi_level_prev_nxt = head.nmi_level;

          if (irq_hold_r != 3'd0) irq_hold_nxt = hold_dec(irq_hold_r);
          if (irq_flag_r && irq_hold_nxt == 3'd0 && (virq_en_r || hirq_en_r)) begin
            irq_pending_nxt = 1'b1;
          end
          match = (virq_en_r || hirq_en_r)
                  && !(virq_en_r && (never_r || head.irq_vpos != vtrigger_r))
                  && !(hirq_en_r && (never_r || head.irq_hpos != htrigger_r));
          if (!irq_match_prev_r && match) begin
            irq_flag_nxt = 1'b1;
            irq_hold_nxt = HOLD_START;
          end
          irq_match_prev_nxt = match;
        end
        cnit_pkg::REQ_EN_WRITE: begin
          nmi_en_nxt  = head.en_nmi;
          virq_en_nxt = head.en_virq;
          hirq_en_nxt = head.en_hirq;
          if (!nmi_en_r && head.en_nmi && nmi_flag_r) nmi_pending_nxt = 1'b1;
          if (head.en_virq && !head.en_hirq && irq_flag_r) irq_pending_nxt = 1'b1;
          if (!head.en_virq && !head.en_hirq) begin
            irq_flag_nxt    = 1'b0;
            irq_pending_nxt = 1'b0;
          end
          refresh = 1'b1;
          ref_hen = head.en_hirq;
        end
        cnit_pkg::REQ_TIMER_WRITE: begin
          vtime_nxt = head.new_vtime;
          htime_nxt = head.new_htime;
          refresh   = 1'b1;
          ref_v     = head.new_vtime;
          ref_h     = head.new_htime;
        end
        cnit_pkg::REQ_NMI_READ: begin
          read_bit_nxt = nmi_flag_r;
          if (nmi_hold_r == 3'd0) nmi_flag_nxt = 1'b0;
        end
        cnit_pkg::REQ_IRQ_READ: begin
          read_bit_nxt = irq_flag_r;
          if (irq_hold_r == 3'd0) begin
            irq_flag_nxt    = 1'b0;
            irq_pending_nxt = 1'b0;
          end
        end
        cnit_pkg::REQ_NMI_TEST: begin
          if (nmi_pending_r) begin
            nmi_pending_nxt = 1'b0;
            nmi_taken_nxt   = 1'b1;
            wake_nxt        = 1'b1;
          end
        end
        cnit_pkg::REQ_IRQ_TEST: begin
          if (irq_pending_r) begin
            irq_pending_nxt = 1'b0;
            wake_nxt        = 1'b1;
            irq_taken_nxt   = !head.irq_disable;
          end
        end
        default: begin
        end
      endcase
    end

    // Trigger positions follow every enable or timer write, or are marked never when the position cannot match.
    h_sum = {1'b0, ref_h} + 10'd1;
    if (refresh) begin
      if (can_latch(ref_v, ref_h, ref_hen, region_pal, head.interlace, head.field_odd)) begin
        never_nxt    = 1'b0;
        vtrigger_nxt = ref_v;
        htrigger_nxt = ref_hen ? {h_sum[8:0], 2'b00} : 11'd0;
      end else begin
        never_nxt = 1'b1;
      end
    end

    out_valid_nxt = pop ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nmi_en_r         <= 1'b0;
      virq_en_r        <= 1'b0;
      hirq_en_r        <= 1'b0;
      nmi_pending_r    <= 1'b0;
      irq_pending_r    <= 1'b0;
      nmi_flag_r       <= 1'b0;
      irq_flag_r       <= 1'b0;
      nmi_level_prev_r <= 1'b0;
      irq_match_prev_r <= 1'b0;
      nmi_hold_r       <= 3'd0;
      irq_hold_r       <= 3'd0;
      vtime_r          <= 9'h1ff;
      htime_r          <= 9'h1ff;
      vtrigger_r       <= 9'd0;
      htrigger_r       <= 11'd0;
      never_r          <= 1'b1;
      out_valid_r      <= 1'b0;
    end else begin
      nmi_en_r         <= nmi_en_nxt;
      virq_en_r        <= virq_en_nxt;
      hirq_en_r        <= hirq_en_nxt;
      nmi_pending_r    <= nmi_pending_nxt;
      irq_pending_r    <= irq_pending_nxt;
      nmi_flag_r       <= nmi_flag_nxt;
      irq_flag_r       <= irq_flag_nxt;
      nmi_level_prev_r <= nmi_level_prev_nxt;
      irq_match_prev_r <= irq_match_prev_nxt;
      nmi_hold_r       <= nmi_hold_nxt;
      irq_hold_r       <= irq_hold_nxt;
      vtime_r          <= vtime_nxt;
      htime_r          <= htime_nxt;
      vtrigger_r       <= vtrigger_nxt;
      htrigger_r       <= htrigger_nxt;
      never_r          <= never_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Result payload, loaded only when a new beat is produced.
  always_ff @(posedge clk) begin
    if (pop) begin
      read_bit_r     <= read_bit_nxt;
      nmi_taken_r    <= nmi_taken_nxt;
      irq_taken_r    <= irq_taken_nxt;
      wake_r         <= wake_nxt;
      nmi_flag_out_r <= nmi_flag_nxt;
      irq_flag_out_r <= irq_flag_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_bit     = read_bit_r;
  assign out_ch.nmi_taken    = nmi_taken_r;
  assign out_ch.irq_taken    = irq_taken_r;
  assign out_ch.wake         = wake_r;
  assign out_ch.nmi_line_out = nmi_flag_out_r;
  assign out_ch.irq_line_out = irq_flag_out_r;

endmodule

`default_nettype wire

### rtl/console_nmi_irq_timer_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Vertical-blank NMI and H/V position IRQ controller for a console CPU.
// Requests arrive as beats on in_ch: poll ticks with delayed beam positions,
// enable and timer writes, flag reads with clear, and NMI/IRQ acknowledge
// tests. Every request beat produces exactly one result beat on out_ch, in
// order, carrying the read bit, the taken and wake flags and the line flags.
// A classifier decodes each beat and feeds a short queue; the executor pops
// one entry per cycle while out_ch is not stalled, updates the edge, hold and
// trigger state and loads the output register.
// An input beat is registered in the queue and then in the output register
// before it reaches out_ch. Throughput is one beat per cycle when out_ch is
// not stalled, set by the executor's state update, on which every request depends.
// When out_ch stalls, the output register holds its beat, the executor stops
// popping, and the queue absorbs up to QUEUE_DEPTH more beats before in_ch.ready
// drops. The user must write the region register (APB word 0, bit 0 selects the
// PAL line limit) only while idle; the block itself does not enforce this.
// Synchronous reset clears the queue and output valid, clears all enables,
// flags and hold counters, sets both timer positions to 0x1ff and marks the
// IRQ trigger as never. There is no clearing pass after reset.
module console_nmi_irq_timer_controller #(
  parameter int QUEUE_DEPTH = cnit_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  cnit_in_if.sink     in_ch,
  cnit_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration port. The only register is the region select at word 0.
  logic region_pal_r;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == cnit_pkg::REG_REGION_PAL) ? {31'd0, region_pal_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_pal_r <= 1'b0;
    end else if (cfg_write && paddr[2] == cnit_pkg::REG_REGION_PAL) begin
      region_pal_r <= pwdata[0];
    end
  end

  // Front end, queue and executor.
  cnit_pkg::item_t   push_item;
  cnit_pkg::item_t   head;
  cnit_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  cnit_front u_front (
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  cnit_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  cnit_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .region_pal (region_pal_r),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  // An accepted beat is always waiting in the queue on the next cycle.
  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !q_stat.empty)
    else $error("accepted beat missing from queue");

  // The executor never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // A stalled result beat is never overwritten by a new one.
  a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !pop)
    else $error("executor advanced while result stalled");

  // Reset leaves nothing in flight.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (q_stat.empty && !out_ch.valid))
    else $error("beats in flight after reset");

endmodule

`default_nettype wire
